@@ hw/rtl/fvn_pkg.sv @@
// Package for the fractal value noise core: widths, defaults, codes.
// Used by every other file of the block; depends on nothing.
package fvn_pkg;

  // Parameter defaults
  localparam int SIZE_EXP_DEF    = 5;
  localparam int MAX_OCTAVES_DEF = 8;

  // Field widths
  localparam int INDEX_W = 15;
  localparam int COORD_W = 32;
  localparam int GAIN_W  = 17;
  localparam int NOISE_W = 17;
  localparam int OCTC_W  = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  // Shared multiplier operand and product widths
  localparam int MUL_A_W = 34;
  localparam int MUL_B_W = 18;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // Q1.16 one
  localparam logic [16:0] ONE_Q16 = 17'd65536;

  // Reset values of the configuration registers
  localparam logic [OCTC_W-1:0] OCT_RESET  = 4'd4;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 17'd32768;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OCTAVES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN    = 2'd1;

  // Opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Operands for the shared multiplier
  typedef struct packed {
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_op_t;

endpackage

@@ hw/rtl/fvn_if.sv @@
// Channel interfaces of the noise core: request, result and register write.
// Depends on fvn_pkg.
interface fvn_req_if import fvn_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      opcode;
  logic [INDEX_W-1:0]        lattice_index;
  logic                      lattice_bit;
  logic signed [COORD_W-1:0] x_pos;
  logic signed [COORD_W-1:0] y_pos;
  logic signed [COORD_W-1:0] z_pos;
  logic                      gain_select;
  logic [GAIN_W-1:0]         gain_value;
  modport source (output valid, opcode, lattice_index, lattice_bit, x_pos, y_pos, z_pos,
                  gain_select, gain_value, input ready);
  modport sink (input valid, opcode, lattice_index, lattice_bit, x_pos, y_pos, z_pos,
                gain_select, gain_value, output ready);
endinterface

interface fvn_rsp_if import fvn_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [NOISE_W-1:0] noise_value;
  modport source (output valid, noise_value, input ready);
  modport sink (input valid, noise_value, output ready);
endinterface

interface fvn_cfg_if import fvn_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ hw/rtl/fvn_mul.sv @@
// Shared unsigned multiplier with a registered product.
// Depends on fvn_pkg.
module fvn_mul import fvn_pkg::*; (
  input  logic               clk,
  input  mul_op_t            op,
  output logic [MUL_P_W-1:0] p
);

  // Product lands in the cycle after the operands
  always_ff @(posedge clk) begin
    p <= MUL_P_W'(op.a) * MUL_P_W'(op.b);
  end

endmodule

@@ hw/rtl/fvn_lattice.sv @@
// One-bit lattice store: one write port, one read port with registered data.
// Depends on fvn_pkg.
module fvn_lattice import fvn_pkg::*; #(
  parameter int AW = 3 * SIZE_EXP_DEF
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic          wdata,
  input  logic [AW-1:0] raddr,
  output logic          rdata
);

  logic mem [0:(1 << AW)-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/fractal_value_noise_3d_core.sv @@
// Top level of the fractal value noise core: sequencer, accumulators, divider.
// Depends on fvn_pkg, fvn_if, fvn_mul and fvn_lattice.
//
//  channel | role   | transaction
//  --------+--------+------------------------------------------------
//  req     | sink   | lattice bit write or noise query
//  rsp     | source | one noise_value per query
//  cfg     | sink   | register write: index 0 octave_count, 1 default_gain
//
// A lattice write is stored when it is accepted. A query steps through each
// octave on the shared multiplier (smoothstep, corner weights, amplitude), then
// runs a restoring division and hands the result to rsp.
// rst is synchronous; it restores the register defaults, lattice is not cleared.
// req is not ready while a query runs; a stalled rsp holds the result and the
// block finishes its next query only once the result register is free.
module fractal_value_noise_3d_core import fvn_pkg::*; #(
  parameter int SIZE_EXP    = SIZE_EXP_DEF,
  parameter int MAX_OCTAVES = MAX_OCTAVES_DEF
) (
  input logic      clk,
  input logic      rst,
  fvn_req_if.sink   req,
  fvn_rsp_if.source rsp,
  fvn_cfg_if.sink   cfg
);

  localparam int S      = SIZE_EXP;
  localparam int AW     = 3 * S;
  localparam int OCT_W  = $clog2(MAX_OCTAVES + 1);
  localparam int NORM_W = 17 + $clog2(MAX_OCTAVES);
  localparam int ACC_W  = NORM_W + 16;
  localparam int RW     = ACC_W + 1;

  // Step codes within one octave
  localparam logic [4:0] SX_SQ = 5'd0,  SX_CU = 5'd1,  SY_SQ = 5'd2,  SY_CU = 5'd3;
  localparam logic [4:0] SZ_SQ = 5'd4,  SZ_CU = 5'd5;
  localparam logic [4:0] C00_XY = 5'd6,  C00_Z0 = 5'd7,  C00_Z1 = 5'd8;
  localparam logic [4:0] C01_XY = 5'd9,  C01_Z0 = 5'd10, C01_Z1 = 5'd11;
  localparam logic [4:0] C10_XY = 5'd12, C10_Z0 = 5'd13, C10_Z1 = 5'd14;
  localparam logic [4:0] C11_XY = 5'd15, C11_Z0 = 5'd16, C11_Z1 = 5'd17;
  localparam logic [4:0] ST_AMP = 5'd18, ST_BLEND = 5'd19, ST_ACC = 5'd20;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_OCT  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t state;

  // Configuration registers
  logic [OCTC_W-1:0] octave_count;
  logic [GAIN_W-1:0] default_gain;

  // Query registers
  logic signed [COORD_W-1:0] xq, yq, zq;
  logic [16:0]        gain, amp;
  logic [OCT_W-1:0]   n_lim, oct;
  logic [4:0]         step;
  logic [NORM_W-1:0]  norm;
  logic [ACC_W-1:0]   acc;
  logic [49:0]        sum;
  logic [16:0]        wx0, wx1, wy0, wy1, wz0, wz1;
  logic [33:0]        wxy;
  logic [RW-1:0]      rem;
  logic [ACC_W-1:0]   dvs;
  logic [NOISE_W-1:0] quo;
  logic [4:0]         dcnt;
  logic               out_valid;
  logic [NOISE_W-1:0] out_value;

  // Shared units
  mul_op_t            mop;
  logic [MUL_P_W-1:0] p;
  logic               rbit;
  logic [AW-1:0]      raddr;
  logic [AW+INDEX_W-1:0] waddr_ext;
  logic               lat_we;

  fvn_mul u_mul (.clk(clk), .op(mop), .p(p));

  fvn_lattice #(.AW(AW)) u_lat (
    .clk(clk), .we(lat_we), .waddr(waddr_ext[AW-1:0]), .wdata(req.lattice_bit),
    .raddr(raddr), .rdata(rbit)
  );

  // Handshakes
  logic req_acc, out_free, last_oct;
  assign req.ready = !rst && (state == ST_IDLE);
  assign req_acc   = req.valid && req.ready;
  assign cfg.ready = !rst;
  assign rsp.valid = out_valid;
  assign rsp.noise_value = out_value;
  assign out_free  = !out_valid || rsp.ready;
  assign lat_we    = req_acc && (req.opcode == OP_WRITE);
  assign waddr_ext = {{AW{1'b0}}, req.lattice_index};
  assign last_oct  = (oct == n_lim - OCT_W'(1));

  // Cell coordinates and fractions
  logic [S-1:0]  cx, cy, cz, cx1, cy1, cz1;
  logic [15:0]   fx, fy, fz;
  assign cx  = xq[16 +: S];
  assign cy  = yq[16 +: S];
  assign cz  = zq[16 +: S];
  assign cx1 = cx + S'(1);
  assign cy1 = cy + S'(1);
  assign cz1 = cz + S'(1);
  assign fx  = xq[15:0];
  assign fy  = yq[15:0];
  assign fz  = zq[15:0];

  // Rounded views of the product and sum
  logic [MUL_P_W-1:0] p_rnd32;
  logic [16:0]        s_w, blend, amp_new;
  logic [49:0]        sum_rnd;
  logic [33:0]        amp_rnd;
  logic [49:0]        sum_add;
  assign p_rnd32 = p + MUL_P_W'(64'h8000_0000);
  assign s_w     = p_rnd32[48:32];
  assign sum_rnd = sum + 50'h8000_0000;
  assign blend   = sum_rnd[48:32];
  assign amp_rnd = p[33:0] + 34'd32768;
  assign amp_new = amp_rnd[32:16];
  assign sum_add = rbit ? (sum + p[49:0]) : sum;

  function automatic logic [17:0] tpoly(input logic [15:0] f);
    tpoly = 18'd196608 - {1'b0, f, 1'b0};
  endfunction

  // Operand and read address selection per step
  always_comb begin
    mop   = '0;
    raddr = {cx, cy, cz};
    case (step)
      SX_SQ:  begin mop.a = 34'(fx); mop.b = 18'(fx); end
      SX_CU:  begin mop.a = 34'(p[31:0]); mop.b = tpoly(fx); end
      SY_SQ:  begin mop.a = 34'(fy); mop.b = 18'(fy); end
      SY_CU:  begin mop.a = 34'(p[31:0]); mop.b = tpoly(fy); end
      SZ_SQ:  begin mop.a = 34'(fz); mop.b = 18'(fz); end
      SZ_CU:  begin mop.a = 34'(p[31:0]); mop.b = tpoly(fz); end
      C00_XY: begin mop.a = 34'(wx0); mop.b = 18'(wy0); end
      C00_Z0: begin mop.a = p[33:0]; mop.b = 18'(wz0); raddr = {cx, cy, cz}; end
      C00_Z1: begin mop.a = wxy; mop.b = 18'(wz1); raddr = {cx, cy, cz1}; end
      C01_XY: begin mop.a = 34'(wx0); mop.b = 18'(wy1); end
      C01_Z0: begin mop.a = p[33:0]; mop.b = 18'(wz0); raddr = {cx, cy1, cz}; end
      C01_Z1: begin mop.a = wxy; mop.b = 18'(wz1); raddr = {cx, cy1, cz1}; end
      C10_XY: begin mop.a = 34'(wx1); mop.b = 18'(wy0); end
      C10_Z0: begin mop.a = p[33:0]; mop.b = 18'(wz0); raddr = {cx1, cy, cz}; end
      C10_Z1: begin mop.a = wxy; mop.b = 18'(wz1); raddr = {cx1, cy, cz1}; end
      C11_XY: begin mop.a = 34'(wx1); mop.b = 18'(wy1); end
      C11_Z0: begin mop.a = p[33:0]; mop.b = 18'(wz0); raddr = {cx1, cy1, cz}; end
      C11_Z1: begin mop.a = wxy; mop.b = 18'(wz1); raddr = {cx1, cy1, cz1}; end
      ST_AMP: begin mop.a = 34'(amp); mop.b = 18'(gain); end
      ST_BLEND: begin mop.a = 34'(blend); mop.b = 18'(amp); end
      default: begin mop = '0; end
    endcase
  end

  // Query set-up values
  logic [4:0]        oc5;
  logic [GAIN_W-1:0] g_raw;
  logic [OCT_W-1:0]  n_new;
  logic [ACC_W-1:0]  acc_new;
  logic [RW-1:0]     dvs_ext;
  assign oc5   = {1'b0, octave_count};
  assign g_raw = req.gain_select ? req.gain_value : default_gain;
  assign acc_new = acc + ACC_W'(p[33:0]);
  assign dvs_ext = RW'(dvs);
  always_comb begin
    if (oc5 == 5'd0) begin
      n_new = OCT_W'(1);
    end else if (oc5 > 5'(MAX_OCTAVES)) begin
      n_new = OCT_W'(MAX_OCTAVES);
    end else begin
      n_new = OCT_W'(oc5);
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      octave_count <= OCT_RESET;
      default_gain <= GAIN_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_OCTAVES: octave_count <= cfg.data[OCTC_W-1:0];
        REG_GAIN:    default_gain <= cfg.data[GAIN_W-1:0];
        default:     ;
      endcase
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= SX_SQ;
      out_valid <= 1'b0;
    end else begin
      // result leaves; hand-off below refills it in the same cycle
      if (out_valid && rsp.ready && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req_acc && (req.opcode == OP_QUERY)) begin
            state <= ST_OCT;
            step  <= SX_SQ;
          end
        end
        ST_OCT: begin
          if (step == ST_ACC) begin
            step <= SX_SQ;
            if (last_oct) begin
              state <= ST_DIV;
            end
          end else begin
            step <= step + 5'd1;
          end
        end
        ST_DIV: begin
          if (dcnt == 5'd0) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (req_acc) begin
      xq    <= req.x_pos;
      yq    <= req.y_pos;
      zq    <= req.z_pos;
      gain  <= (g_raw > ONE_Q16) ? ONE_Q16 : g_raw;
      n_lim <= n_new;
      oct   <= '0;
      amp   <= ONE_Q16;
      norm  <= '0;
      acc   <= '0;
    end
    if (state == ST_OCT) begin
      case (step)
        SX_SQ:  sum <= '0;
        SY_SQ:  begin wx1 <= s_w; wx0 <= ONE_Q16 - s_w; end
        SZ_SQ:  begin wy1 <= s_w; wy0 <= ONE_Q16 - s_w; end
        C00_XY: begin wz1 <= s_w; wz0 <= ONE_Q16 - s_w; end
        C00_Z0, C01_Z0, C10_Z0, C11_Z0: wxy <= p[33:0];
        C00_Z1, C01_XY, C01_Z1, C10_XY, C10_Z1, C11_XY, C11_Z1, ST_AMP: sum <= sum_add;
        ST_BLEND: begin
          amp  <= amp_new;
          norm <= norm + NORM_W'(amp);
        end
        ST_ACC: begin
          acc <= acc_new;
          xq  <= xq >>> 1;
          yq  <= yq >>> 1;
          zq  <= zq >>> 1;
          oct <= oct + OCT_W'(1);
          // divider set-up: dividend rounded by half the divisor
          rem  <= RW'(acc_new) + RW'(norm >> 1);
          dvs  <= {norm, 16'd0};
          dcnt <= 5'd16;
        end
        default: ;
      endcase
    end
    // Restoring division, one quotient bit a cycle
    if (state == ST_DIV) begin
      if (rem >= dvs_ext) begin
        rem <= rem - dvs_ext;
        quo <= {quo[NOISE_W-2:0], 1'b1};
      end else begin
        quo <= {quo[NOISE_W-2:0], 1'b0};
      end
      dvs  <= dvs >> 1;
      dcnt <= dcnt - 5'd1;
    end
    if (state == ST_DONE && out_free) begin
      out_value <= quo;
    end
  end

  // Checks
  a_norm_floor: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (norm >= NORM_W'(ONE_Q16)))
    else $error("divisor below one at division");
  a_oct_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OCT) |-> (oct < n_lim))
    else $error("octave counter past limit");
  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state == ST_DONE))
    else $error("result raised outside hand-off");
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OCT) |-> (step <= ST_ACC))
    else $error("step code out of range");

endmodule
